FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPLY(name, ck, rn, a, c) \
    name: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define ASSERT_NEXT(name, ck, rn, a, c) \
    name: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: src/cmpcal_pkg.sv
`default_nettype none

package cmpcal_pkg;

    localparam int unsigned STEPS      = 20;
    localparam int unsigned DATA_W     = 16;
    localparam int unsigned GAIN_W     = 15;
    localparam int unsigned FUNC_W     = 3;
    localparam int unsigned PROD_W     = 31;
    localparam int unsigned X_W        = 27;
    localparam int unsigned Z_W        = 26;
    localparam int unsigned H_W        = 36;
    localparam int unsigned R_W        = 32;
    localparam int unsigned HEAD_W     = 9;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_START  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECL = 1'b1;

    localparam logic [GAIN_W-1:0]        GAIN_RESET = 15'd30147;
    localparam logic signed [DATA_W-1:0] MIN_RESET  = 16'sd1000;
    localparam logic signed [DATA_W-1:0] MAX_RESET  = -16'sd1000;

    localparam logic signed [Z_W-1:0] DEG90_Q16    = Z_W'(5898240);
    localparam logic signed [H_W-1:0] CDEG_PER_DEG = H_W'(100);
    localparam logic signed [H_W-1:0] DEG_OFFSET   = H_W'(589824000);
    localparam logic signed [H_W-1:0] FULL_CIRCLE  = H_W'(64'sd2359296000);
    localparam logic [DATA_W-1:0]     RECIP_100    = 16'd41944;
    localparam int unsigned           RECIP_SHIFT  = 22;

    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } cell_t;

    // atan(2^-i) in degrees q16
    function automatic logic signed [Z_W-1:0] atan_q16(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(2949120);
            1:       v = Z_W'(1740967);
            2:       v = Z_W'(919879);
            3:       v = Z_W'(466945);
            4:       v = Z_W'(234379);
            5:       v = Z_W'(117304);
            6:       v = Z_W'(58666);
            7:       v = Z_W'(29335);
            8:       v = Z_W'(14668);
            9:       v = Z_W'(7334);
            10:      v = Z_W'(3667);
            11:      v = Z_W'(1833);
            12:      v = Z_W'(917);
            13:      v = Z_W'(458);
            14:      v = Z_W'(229);
            15:      v = Z_W'(115);
            16:      v = Z_W'(57);
            17:      v = Z_W'(29);
            18:      v = Z_W'(14);
            19:      v = Z_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: src/compass_heading_with_offset_calibration.sv
// compass heading with hard-iron offset calibration
//
// input stream: one beat per sample pair; tuser carries the function code
// (measure, start calibration, calibration sample, finish calibration, load
// offsets), tdata the signed x and y readings. output stream: one beat per
// input beat with the heading in whole degrees and the current x and y offsets.
// the config port writes the q15 gain and the declination; write it only
// while no beat is in flight.
// from input beat to output valid a beat passes the input register, offset
// removal with q15 scaling, the quadrant rotation, a row of 20 vectoring
// cells, the heading register, the wrap register with the degree conversion
// behind it, and the output register.
// one beat is in flight at a time: a new beat is taken only once the last one
// has been loaded into the output register.
// a stalled sink freezes the whole pipeline and the output register holds its
// beat; the next input beat is taken meanwhile and waits in the input register.
// reset clears the pipeline, sets min to 1000, max to -1000, offsets to zero,
// gain to 0.92 and declination to zero.
`default_nettype none

module compass_heading_with_offset_calibration (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [31:0]                         s_axis_tdata,  // sample_x, sample_y
    input  wire logic [cmpcal_pkg::FUNC_W-1:0]       s_axis_tuser,  // func
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [47:0]                              m_axis_tdata,  // heading_deg, offset_x_out, offset_y_out
    input  wire logic                                cfg_we,
    input  wire logic [cmpcal_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [cmpcal_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int unsigned DW    = cmpcal_pkg::DATA_W;
    localparam int unsigned HDW   = cmpcal_pkg::HEAD_W;
    localparam int unsigned STEPS = cmpcal_pkg::STEPS;

    logic [cmpcal_pkg::GAIN_W-1:0] gain_reg;
    logic signed [DW-1:0]          decl_reg;
    logic                          busy_reg;
    logic                          out_valid_reg;
    logic [HDW-1:0]                out_head_reg;
    logic signed [DW-1:0]          out_ox_reg;
    logic signed [DW-1:0]          out_oy_reg;

    logic                          accept;
    logic                          adv;
    logic                          load;
    logic                          post_valid;
    logic [HDW-1:0]                post_heading;
    logic signed [DW-1:0]          offset_x;
    logic signed [DW-1:0]          offset_y;

    cmpcal_pkg::cell_t chain [0:STEPS];

    assign accept        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = ~busy_reg;
    assign adv           = ~out_valid_reg | m_axis_tready;
    assign load          = post_valid & adv;

    cmpcal_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .func     (s_axis_tuser),
        .sample_x (s_axis_tdata[DW-1:0]),
        .sample_y (s_axis_tdata[2*DW-1:DW]),
        .gain     (gain_reg),
        .adv      (adv),
        .cell_out (chain[0]),
        .offset_x (offset_x),
        .offset_y (offset_y)
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        cmpcal_cell #(
            .STEP (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .d     (chain[i]),
            .q     (chain[i+1])
        );
    end

    cmpcal_post u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .d       (chain[STEPS]),
        .decl    (decl_reg),
        .valid   (post_valid),
        .heading (post_heading)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= cmpcal_pkg::GAIN_RESET;
            decl_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    cmpcal_pkg::CFG_GAIN: gain_reg <= cfg_wdata[cmpcal_pkg::GAIN_W-1:0];
                    cmpcal_pkg::CFG_DECL: decl_reg <= cfg_wdata;
                endcase
            end
            if (accept)
                busy_reg <= 1'b1;
            else if (load)
                busy_reg <= 1'b0;
            if (adv)
                out_valid_reg <= post_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_head_reg <= post_heading;
            out_ox_reg   <= offset_x;
            out_oy_reg   <= offset_y;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_oy_reg, out_ox_reg, out_head_reg};

endmodule

`default_nettype wire

FILE: src/cmpcal_front.sv
`default_nettype none

module cmpcal_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  accept,
    input  wire logic [cmpcal_pkg::FUNC_W-1:0]         func,
    input  wire logic signed [cmpcal_pkg::DATA_W-1:0]  sample_x,
    input  wire logic signed [cmpcal_pkg::DATA_W-1:0]  sample_y,
    input  wire logic [cmpcal_pkg::GAIN_W-1:0]         gain,
    input  wire logic                                  adv,
    output cmpcal_pkg::cell_t                          cell_out,
    output logic signed [cmpcal_pkg::DATA_W-1:0]       offset_x,
    output logic signed [cmpcal_pkg::DATA_W-1:0]       offset_y
);

    localparam int unsigned DW = cmpcal_pkg::DATA_W;
    localparam int unsigned PW = cmpcal_pkg::PROD_W;
    localparam int unsigned XW = cmpcal_pkg::X_W;

    function automatic logic signed [DW-1:0] calib_offset(
        input logic signed [DW-1:0] mx,
        input logic signed [DW-1:0] mn
    );
        logic [DW:0]          ax;
        logic [DW:0]          an;
        logic [DW+1:0]        sum;
        logic signed [DW+2:0] v;
        ax  = mx[DW-1] ? (DW+1)'(-{mx[DW-1], mx}) : {1'b0, mx};
        an  = mn[DW-1] ? (DW+1)'(-{mn[DW-1], mn}) : {1'b0, mn};
        sum = {1'b0, ax} + {1'b0, an};
        v   = $signed({2'b00, sum[DW+1:1]}) + (DW+3)'(mn);
        return v[DW-1:0];
    endfunction

    // truncate toward zero after the q15 product
    function automatic logic signed [DW-1:0] trunc_q15(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p[PW-1] ? p + PW'(32767) : p;
        return t[PW-1:PW-DW];
    endfunction

    logic signed [DW-1:0] min_x_reg, min_x_next;
    logic signed [DW-1:0] max_x_reg, max_x_next;
    logic signed [DW-1:0] min_y_reg, min_y_next;
    logic signed [DW-1:0] max_y_reg, max_y_next;
    logic signed [DW-1:0] off_x_reg, off_x_next;
    logic signed [DW-1:0] off_y_reg, off_y_next;

    logic                 s0_valid_reg;
    logic signed [DW-1:0] s0_x_reg;
    logic signed [DW-1:0] s0_y_reg;
    logic                 s1_valid_reg;
    logic signed [PW-1:0] s1_px_reg;
    logic signed [PW-1:0] s1_py_reg;
    logic                 c_valid_reg;
    cmpcal_pkg::cell_t    c_data_reg, c_data_next;

    logic signed [DW-1:0] cx;
    logic signed [DW-1:0] cy;
    logic signed [2*DW-1:0] px;
    logic signed [2*DW-1:0] py;
    logic signed [DW-1:0] sx;
    logic signed [DW-1:0] sy;
    logic signed [XW-1:0] wx;
    logic signed [XW-1:0] wy;

    always_comb
    begin
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        off_x_next = off_x_reg;
        off_y_next = off_y_reg;
        if (accept)
        begin
            unique case (func)
                cmpcal_pkg::FUNC_START:
                begin
                    min_x_next = cmpcal_pkg::MIN_RESET;
                    max_x_next = cmpcal_pkg::MAX_RESET;
                    min_y_next = cmpcal_pkg::MIN_RESET;
                    max_y_next = cmpcal_pkg::MAX_RESET;
                end
                cmpcal_pkg::FUNC_SAMPLE:
                begin
                    if (sample_x > max_x_reg) max_x_next = sample_x;
                    if (sample_x < min_x_reg) min_x_next = sample_x;
                    if (sample_y > max_y_reg) max_y_next = sample_y;
                    if (sample_y < min_y_reg) min_y_next = sample_y;
                end
                cmpcal_pkg::FUNC_FINISH:
                begin
                    off_x_next = calib_offset(max_x_reg, min_x_reg);
                    off_y_next = calib_offset(max_y_reg, min_y_reg);
                end
                cmpcal_pkg::FUNC_LOAD:
                begin
                    off_x_next = sample_x;
                    off_y_next = sample_y;
                end
                default: ;
            endcase
        end
    end

    // remove offset and scale
    always_comb
    begin
        cx = s0_x_reg - off_x_reg;
        cy = s0_y_reg - off_y_reg;
        px = (2*DW)'(cx) * (2*DW)'($signed({1'b0, gain}));
        py = (2*DW)'(cy) * (2*DW)'($signed({1'b0, gain}));
    end

    // quadrant pre-rotation into the right half plane
    always_comb
    begin
        sx = trunc_q15(s1_px_reg);
        sy = trunc_q15(s1_py_reg);
        wx = {{(XW-DW-8){sx[DW-1]}}, sx, 8'b0};
        wy = {{(XW-DW-8){sy[DW-1]}}, sy, 8'b0};
        c_data_next       = '0;
        c_data_next.valid = s1_valid_reg;
        c_data_next.zero  = (sx == '0) && (sy == '0);
        c_data_next.x     = wx;
        c_data_next.y     = wy;
        c_data_next.z     = '0;
        if (wx[XW-1])
        begin
            if (!wy[XW-1])
            begin
                c_data_next.x = wy;
                c_data_next.y = -wx;
                c_data_next.z = cmpcal_pkg::DEG90_Q16;
            end
            else
            begin
                c_data_next.x = -wy;
                c_data_next.y = wx;
                c_data_next.z = -cmpcal_pkg::DEG90_Q16;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg    <= cmpcal_pkg::MIN_RESET;
            max_x_reg    <= cmpcal_pkg::MAX_RESET;
            min_y_reg    <= cmpcal_pkg::MIN_RESET;
            max_y_reg    <= cmpcal_pkg::MAX_RESET;
            off_x_reg    <= '0;
            off_y_reg    <= '0;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            c_valid_reg  <= 1'b0;
        end
        else
        begin
            min_x_reg    <= min_x_next;
            max_x_reg    <= max_x_next;
            min_y_reg    <= min_y_next;
            max_y_reg    <= max_y_next;
            off_x_reg    <= off_x_next;
            off_y_reg    <= off_y_next;
            s0_valid_reg <= accept | (s0_valid_reg & ~adv);
            if (adv)
            begin
                s1_valid_reg <= s0_valid_reg;
                c_valid_reg  <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_x_reg <= sample_x;
            s0_y_reg <= sample_y;
        end
        if (adv)
        begin
            s1_px_reg  <= px[PW-1:0];
            s1_py_reg  <= py[PW-1:0];
            c_data_reg <= c_data_next;
        end
    end

    always_comb
    begin
        cell_out       = c_data_reg;
        cell_out.valid = c_valid_reg;
    end

    assign offset_x = off_x_reg;
    assign offset_y = off_y_reg;

endmodule

`default_nettype wire

FILE: src/cmpcal_cell.sv
`default_nettype none

module cmpcal_cell #(
    parameter int unsigned STEP = 0
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  wire cmpcal_pkg::cell_t d,
    output cmpcal_pkg::cell_t q
);

    localparam int unsigned XW = cmpcal_pkg::X_W;
    localparam int unsigned ZW = cmpcal_pkg::Z_W;

    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] ang;

    logic                 valid_reg;
    cmpcal_pkg::cell_t    data_reg, data_next;

    // one vectoring micro-rotation
    always_comb
    begin
        x   = d.x;
        y   = d.y;
        z   = d.z;
        ang = cmpcal_pkg::atan_q16(STEP);
        dx  = x >>> STEP;
        dy  = y >>> STEP;
        data_next = d;
        if (!y[XW-1])
        begin
            data_next.x = x + dy;
            data_next.y = y - dx;
            data_next.z = z + ang;
        end
        else
        begin
            data_next.x = x - dy;
            data_next.y = y + dx;
            data_next.z = z - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

`default_nettype wire

FILE: src/cmpcal_post.sv
`default_nettype none

module cmpcal_post (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 adv,
    input  wire cmpcal_pkg::cell_t                    d,
    input  wire logic signed [cmpcal_pkg::DATA_W-1:0] decl,
    output logic                                      valid,
    output logic [cmpcal_pkg::HEAD_W-1:0]             heading
);

    localparam int unsigned HW = cmpcal_pkg::H_W;
    localparam int unsigned RW = cmpcal_pkg::R_W;
    localparam int unsigned ZW = cmpcal_pkg::Z_W;
    localparam int unsigned DW = cmpcal_pkg::DATA_W;

    logic signed [ZW-1:0] zv;
    logic signed [HW-1:0] h_next;
    logic signed [HW-1:0] dterm;
    logic signed [HW-1:0] r_full;
    logic [2*DW-1:0]      qprod;

    logic                 a_valid_reg;
    logic signed [HW-1:0] a_h_reg;
    logic                 b_valid_reg;
    logic [RW-1:0]        b_r_reg;

    // heading in hundredths of a degree q16
    always_comb
    begin
        zv     = d.zero ? '0 : d.z;
        dterm  = HW'(decl) <<< 16;
        h_next = HW'(zv) * cmpcal_pkg::CDEG_PER_DEG - cmpcal_pkg::DEG_OFFSET + dterm;
    end

    // wrap into one full circle
    always_comb
    begin
        if (a_h_reg < -cmpcal_pkg::FULL_CIRCLE)
            r_full = a_h_reg + cmpcal_pkg::FULL_CIRCLE + cmpcal_pkg::FULL_CIRCLE;
        else if (a_h_reg[HW-1])
            r_full = a_h_reg + cmpcal_pkg::FULL_CIRCLE;
        else if (a_h_reg >= cmpcal_pkg::FULL_CIRCLE)
            r_full = a_h_reg - cmpcal_pkg::FULL_CIRCLE;
        else
            r_full = a_h_reg;
    end

    // whole degrees: drop q16, divide by 100 with a reciprocal
    always_comb
    begin
        qprod   = {{DW{1'b0}}, b_r_reg[RW-1:RW-DW]} * (2*DW)'(cmpcal_pkg::RECIP_100);
        heading = qprod[cmpcal_pkg::RECIP_SHIFT +: cmpcal_pkg::HEAD_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= d.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_h_reg <= h_next;
            b_r_reg <= r_full[RW-1:0];
        end
    end

    assign valid = b_valid_reg;

endmodule

`default_nettype wire

FILE: src/cmpcal_checker.sv
`default_nettype none

`include "assert_macros.svh"

module cmpcal_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [47:0]                       m_axis_tdata
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    `ASSERT_IMPLY(a_heading_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[8:0] < 9'd360)

endmodule

bind compass_heading_with_offset_calibration cmpcal_checker u_cmpcal_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
